/* design/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared types and constants for the streaming SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_vars;

    localparam t_vars H_INIT = '{
        a: 32'h6745_2301,
        b: 32'hEFCD_AB89,
        c: 32'h98BA_DCFE,
        d: 32'h1032_5476,
        e: 32'hC3D2_E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A82_7999;
    localparam logic [31:0] K_1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam int          SCHED_DEPTH = 16;
    localparam logic [6:0]  ROUNDS      = 7'd80;
    localparam logic [6:0]  SCHED_START = 7'd16;
    localparam logic [2:0]  LAST_WORD   = 3'd4;

endpackage

/* design/sha1md_wmem.sv */
// ----------------------------------------------------------------------------
// SHA-1 schedule memory
// 16 x 32 schedule window, one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module sha1md_wmem (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [3:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic [3:0]  i_raddr0,
    input  logic [3:0]  i_raddr1,
    output logic [31:0] o_rdata0,
    output logic [31:0] o_rdata1
);
    import sha1md_pkg::*;

    logic [31:0] r_mem [SCHED_DEPTH];
    logic [31:0] r_q0;
    logic [31:0] r_q1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q0 <= r_mem[i_raddr0];
        r_q1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_q0;
    assign o_rdata1 = r_q1;

endmodule

/* design/sha1md_round.sv */
// ----------------------------------------------------------------------------
// SHA-1 round
// Schedule word expansion and one compression round on the working variables.
// ----------------------------------------------------------------------------
module sha1md_round (
    input  logic [6:0]          i_t,
    input  sha1md_pkg::t_vars   i_vars,
    input  logic [31:0]         i_x,
    input  logic [31:0]         i_q0,
    input  logic [31:0]         i_q1,
    output logic [31:0]         o_w,
    output sha1md_pkg::t_vars   o_vars
);
    import sha1md_pkg::*;

    logic [31:0] mix;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] tmp;

    always_comb begin
        mix = i_x ^ i_q0 ^ i_q1;
        o_w = (i_t < SCHED_START) ? i_q1 : {mix[30:0], mix[31]};

        priority if (i_t < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_0;
        end else if (i_t < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_1;
        end else if (i_t < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_3;
        end

        tmp = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + k + o_w;

        o_vars.a = tmp;
        o_vars.b = i_vars.a;
        o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

/* design/sha1_message_digest_top.sv */
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Streaming SHA-1: bytes in, padding and length appended, five digest words out.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  in      | i_in_valid / o_in_ready    | i_data_byte, i_byte_valid, i_last
//  out     | o_out_valid / i_out_ready  | o_digest_word, o_word_index, o_word_last
//
//  Byte items can be taken back to back while idle; the 64th byte of a block adds a
//  compression (a read phase and a compute phase per round, set by the two read
//  ports of the schedule memory, plus one priming read and one chaining add).
//  A last item adds the padding bytes plus one or two compressions, then five
//  digest items. No item is taken while padding, compressing or delivering.
//  Synchronous active-low reset restores the initial chaining words.
// ----------------------------------------------------------------------------
module sha1_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_word_last
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [1:0] P_MARK = 2'd0;
    localparam logic [1:0] P_ZERO = 2'd1;
    localparam logic [1:0] P_LEN  = 2'd2;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret,   n_ret;
    logic [1:0]  r_pst,   n_pst;
    logic [5:0]  r_cnt,   n_cnt;
    logic [63:0] r_len,   n_len;
    logic [23:0] r_word,  n_word;
    logic [6:0]  r_rnd,   n_rnd;
    logic        r_ph,    n_ph;
    logic        r_fin,   n_fin;
    logic [31:0] r_x,     n_x;
    logic [2:0]  r_oi,    n_oi;
    t_vars       r_h,     n_h;
    t_vars       r_vars,  n_vars;

    logic        push_en;
    logic [7:0]  push_byte;
    logic [7:0]  len_byte;
    logic        len_phase;
    logic        in_acc;
    logic        out_acc;

    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr0;
    logic [3:0]  mem_raddr1;
    logic [31:0] mem_q0;
    logic [31:0] mem_q1;

    logic [6:0]  t_fin;
    logic [31:0] rnd_w;
    t_vars       rnd_vars;

    sha1md_wmem u_wmem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_raddr0),
        .i_raddr1 (mem_raddr1),
        .o_rdata0 (mem_q0),
        .o_rdata1 (mem_q1)
    );

    assign t_fin = r_rnd - 7'd1;

    sha1md_round u_round (
        .i_t    (t_fin),
        .i_vars (r_vars),
        .i_x    (r_x),
        .i_q0   (mem_q0),
        .i_q1   (mem_q1),
        .o_w    (rnd_w),
        .o_vars (rnd_vars)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_acc     = o_out_valid & i_out_ready;
    assign len_byte    = 8'(r_len >> {~r_cnt[2:0], 3'b000});
    assign len_phase   = (r_pst == P_LEN) || ((r_pst == P_ZERO) && (r_cnt == 6'd56));

    always_comb begin
        unique case (r_oi)
            3'd0:    o_digest_word = r_h.a;
            3'd1:    o_digest_word = r_h.b;
            3'd2:    o_digest_word = r_h.c;
            3'd3:    o_digest_word = r_h.d;
            default: o_digest_word = r_h.e;
        endcase
    end
    assign o_word_index = r_oi;
    assign o_word_last  = (r_oi == LAST_WORD);

    always_comb begin
        if (r_ph) begin
            mem_raddr0 = r_rnd[3:0] + 4'd2;
            mem_raddr1 = r_rnd[3:0];
        end else begin
            mem_raddr0 = r_rnd[3:0] - 4'd3;
            mem_raddr1 = r_rnd[3:0] - 4'd8;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_pst   = r_pst;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_word  = r_word;
        n_rnd   = r_rnd;
        n_ph    = r_ph;
        n_fin   = r_fin;
        n_x     = r_x;
        n_oi    = r_oi;
        n_h     = r_h;
        n_vars  = r_vars;

        push_en   = 1'b0;
        push_byte = i_data_byte;
        mem_we    = 1'b0;
        mem_waddr = r_cnt[5:2];
        mem_wdata = {r_word, push_byte};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    push_en = i_byte_valid;
                    if (i_byte_valid) begin
                        n_len = r_len + 64'd8;
                    end
                    if (i_last) begin
                        n_state = S_PAD;
                        n_pst   = P_MARK;
                    end
                    n_ret = i_last ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                unique case (r_pst)
                    P_MARK: begin
                        push_byte = PAD_MARK;
                        n_pst     = P_ZERO;
                    end
                    P_ZERO: begin
                        push_byte = len_phase ? len_byte : 8'd0;
                        if (len_phase) begin
                            n_pst = P_LEN;
                        end
                    end
                    default: begin
                        push_byte = len_byte;
                    end
                endcase
                n_ret = (r_pst == P_LEN) ? S_OUT : S_PAD;
            end
            S_COMP: begin
                if (!r_ph) begin
                    if (r_fin) begin
                        n_vars    = rnd_vars;
                        mem_we    = (t_fin >= SCHED_START);
                        mem_waddr = t_fin[3:0];
                        mem_wdata = rnd_w;
                    end
                    if (r_rnd == ROUNDS) begin
                        n_state = S_ADD;
                    end else begin
                        n_ph = 1'b1;
                    end
                end else begin
                    n_x   = mem_q0 ^ mem_q1;
                    n_ph  = 1'b0;
                    n_fin = 1'b1;
                    n_rnd = r_rnd + 7'd1;
                end
            end
            S_ADD: begin
                n_h.a   = r_h.a + r_vars.a;
                n_h.b   = r_h.b + r_vars.b;
                n_h.c   = r_h.c + r_vars.c;
                n_h.d   = r_h.d + r_vars.d;
                n_h.e   = r_h.e + r_vars.e;
                n_state = r_ret;
                n_oi    = 3'd0;
            end
            S_OUT: begin
                if (out_acc) begin
                    if (o_word_last) begin
                        n_h     = H_INIT;
                        n_cnt   = 6'd0;
                        n_len   = 64'd0;
                        n_state = S_IDLE;
                    end else begin
                        n_oi = r_oi + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en) begin
            mem_waddr = r_cnt[5:2];
            mem_wdata = {r_word, push_byte};
            mem_we    = (r_cnt[1:0] == 2'd3);
            n_word    = {r_word[15:0], push_byte};
            n_cnt     = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_state = S_COMP;
                n_rnd   = 7'd0;
                n_ph    = 1'b0;
                n_fin   = 1'b0;
                n_vars  = r_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pst   <= P_MARK;
            r_cnt   <= 6'd0;
            r_len   <= 64'd0;
            r_rnd   <= 7'd0;
            r_ph    <= 1'b0;
            r_fin   <= 1'b0;
            r_oi    <= 3'd0;
            r_h     <= H_INIT;
            r_vars  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pst   <= n_pst;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_rnd   <= n_rnd;
            r_ph    <= n_ph;
            r_fin   <= n_fin;
            r_oi    <= n_oi;
            r_h     <= n_h;
            r_vars  <= n_vars;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_x    <= n_x;
    end

endmodule

/* design/sha1md_checker.sv */
// ----------------------------------------------------------------------------
// SHA-1 digest port checker
// Port-level properties of the digest block, bound to the top level.
// ----------------------------------------------------------------------------
module sha1md_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_word_last
);
    import sha1md_pkg::*;

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest pending");

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_word_last == (o_word_index == LAST_WORD)))
        else $error("word_last does not match word_index");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_word_last) |=>
            (o_out_valid && (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest words not in sequence");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_digest_word) && $stable(o_word_index)))
        else $error("stalled digest item changed");

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_word_last   (o_word_last)
);
